FILE: rtl/iair_pkg.sv
// shared types and codes for the indexed array with insert and remove
// used by iair_cell, indexed_array_insert_remove and iair_check

package iair_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 7;
	localparam int CNT_W  = 7;
	localparam int MODE_W = 3;
	localparam int ST_W   = 2;

	// operation codes carried by a request
	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_INSERT = 3'd1,
		MODE_REMOVE = 3'd2,
		MODE_GET    = 3'd3,
		MODE_SET    = 3'd4,
		MODE_CLEAR  = 3'd5
	} mode_t;

	// status codes returned with every result
	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// per-cell control for one clock
	typedef struct packed {
		logic load;
		logic shift_up;
		logic shift_down;
		logic read;
	} cell_ctrl_t;

endpackage

FILE: rtl/indexed_array_insert_remove.sv
// top level of the ordered word array with insert and remove
// builds a chain of iair_cell instances; depends on iair_pkg

// Ordered array of DEPTH signed 32-bit words with a live count.
// Request channel: req_valid / req_ready carry mode, index and value.
// Result channel: res_valid / res_ready carry read_value, status and count.
// Every request yields exactly one result, in request order.
// Modes: append, insert at index, remove at index, get, set, clear; other
// codes do nothing and report the current count.
// The result is registered at the edge that accepts the request. Throughput
// is one request per cycle while results are taken, set by the cell chain,
// which shifts the entries from the index upward in the same clock.
// The result register frees up when the result is taken, so a request is
// accepted while a result waits only if that result leaves in the same cycle;
// a stalled receiver holds the result steady and stops new requests.
// Reset (arst_n low) empties the array and drops any pending result; entry
// contents are not cleared, only entries below the count are ever read.
// A bad index reports status bad index and leaves the array unchanged, get
// then returns -1; a full array reports full on append or insert.

module indexed_array_insert_remove #(
	parameter int DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [iair_pkg::MODE_W-1:0]        mode,
	input  logic [iair_pkg::IDX_W-1:0]         index,
	input  logic signed [iair_pkg::DATA_W-1:0] value,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [iair_pkg::DATA_W-1:0] read_value,
	output logic [iair_pkg::ST_W-1:0]          status,
	output logic [iair_pkg::CNT_W-1:0]         count
);

	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = (LW > iair_pkg::IDX_W) ? LW : iair_pkg::IDX_W;

	logic [LW-1:0] live_q;
	logic [LW-1:0] live_d;
	logic          res_valid_q;
	logic signed [iair_pkg::DATA_W-1:0] read_value_q;
	logic [iair_pkg::ST_W-1:0]          status_q;
	logic [iair_pkg::CNT_W-1:0]         count_q;

	logic          accept;
	logic [CW-1:0] live_x;
	logic [CW-1:0] live_d_x;
	logic [CW-1:0] idx_x;
	logic [CW-1:0] target_x;
	logic          full;
	logic          idx_lt_live;
	logic          idx_le_live;
	logic          do_load;
	logic          do_up;
	logic          do_down;
	logic          do_read;
	iair_pkg::status_t st_d;
	logic signed [iair_pkg::DATA_W-1:0] rd_d;
	logic signed [iair_pkg::DATA_W-1:0] rd_or;

	iair_pkg::cell_ctrl_t               ctrl  [DEPTH];
	logic signed [iair_pkg::DATA_W-1:0] cdata [DEPTH];
	logic signed [iair_pkg::DATA_W-1:0] ctap  [DEPTH];

	assign accept    = req_valid && req_ready;
	assign req_ready = !res_valid_q || res_ready;

	// index checks against the live count
	assign live_x      = CW'(live_q);
	assign idx_x       = CW'(index);
	assign full        = (live_q == LW'(DEPTH));
	assign idx_lt_live = (idx_x < live_x);
	assign idx_le_live = (idx_x <= live_x);
	assign target_x    = (iair_pkg::mode_t'(mode) == iair_pkg::MODE_APPEND) ? live_x : idx_x;

	// operation decode
	always_comb begin
		do_load = 1'b0;
		do_up   = 1'b0;
		do_down = 1'b0;
		do_read = 1'b0;
		st_d    = iair_pkg::ST_OK;
		live_d  = live_q;
		case (iair_pkg::mode_t'(mode))
			iair_pkg::MODE_APPEND: begin
				if (full) begin
					st_d = iair_pkg::ST_FULL;
				end else begin
					do_load = 1'b1;
					live_d  = live_q + LW'(1);
				end
			end
			iair_pkg::MODE_INSERT: begin
				if (!idx_le_live) begin
					st_d = iair_pkg::ST_BAD_INDEX;
				end else if (full) begin
					st_d = iair_pkg::ST_FULL;
				end else begin
					do_load = 1'b1;
					do_up   = 1'b1;
					live_d  = live_q + LW'(1);
				end
			end
			iair_pkg::MODE_REMOVE: begin
				if (!idx_lt_live) begin
					st_d = iair_pkg::ST_BAD_INDEX;
				end else begin
					do_down = 1'b1;
					live_d  = live_q - LW'(1);
				end
			end
			iair_pkg::MODE_GET: begin
				do_read = 1'b1;
				if (!idx_lt_live) begin
					st_d = iair_pkg::ST_BAD_INDEX;
				end
			end
			iair_pkg::MODE_SET: begin
				if (!idx_lt_live) begin
					st_d = iair_pkg::ST_BAD_INDEX;
				end else begin
					do_load = 1'b1;
				end
			end
			iair_pkg::MODE_CLEAR: begin
				live_d = '0;
			end
			default: begin
			end
		endcase
	end

	// cell chain with per-position control
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [iair_pkg::DATA_W-1:0] lower;
		logic signed [iair_pkg::DATA_W-1:0] upper;

		assign ctrl[i].load       = accept && do_load && (target_x == CW'(i));
		assign ctrl[i].shift_up   = accept && do_up && (CW'(i) > idx_x);
		assign ctrl[i].shift_down = accept && do_down && (CW'(i) >= idx_x);
		assign ctrl[i].read       = do_read && (idx_x == CW'(i));

		if (i == 0) begin : g_bottom
			assign lower = cdata[i];
		end else begin : g_lower
			assign lower = cdata[i-1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign upper = cdata[i];
		end else begin : g_upper
			assign upper = cdata[i+1];
		end

		iair_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.load_data  (value),
			.lower_data (lower),
			.upper_data (upper),
			.data       (cdata[i]),
			.read_tap   (ctap[i])
		);
	end

	// or-combine of the masked read taps
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | ctap[i];
		end
	end

	assign rd_d = (!do_read) ? '0 :
		(st_d == iair_pkg::ST_BAD_INDEX) ? -32'sd1 : rd_or;

	assign live_d_x = CW'(live_d);

	// live count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				live_q <= live_d;
			end
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_d;
			status_q     <= st_d;
			count_q      <= live_d_x[iair_pkg::CNT_W-1:0];
		end
	end

	assign res_valid  = res_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign count      = count_q;

endmodule

FILE: rtl/iair_cell.sv
// one storage cell of the entry chain: holds one word, takes it from the
// request, the lower neighbour or the upper neighbour; depends on iair_pkg

module iair_cell (
	input  logic                              clk,
	input  iair_pkg::cell_ctrl_t              ctrl,
	input  logic signed [iair_pkg::DATA_W-1:0] load_data,
	input  logic signed [iair_pkg::DATA_W-1:0] lower_data,
	input  logic signed [iair_pkg::DATA_W-1:0] upper_data,
	output logic signed [iair_pkg::DATA_W-1:0] data,
	output logic signed [iair_pkg::DATA_W-1:0] read_tap
);

	logic signed [iair_pkg::DATA_W-1:0] data_q;

	// entry update: load wins, then shift towards the top or the bottom
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift_up) begin
			data_q <= lower_data;
		end else if (ctrl.shift_down) begin
			data_q <= upper_data;
		end
	end

	assign data = data_q;

	// masked read for the or-combine at the top level
	assign read_tap = ctrl.read ? data_q : '0;

endmodule

FILE: rtl/iair_check.sv
// port-level checks for indexed_array_insert_remove, attached by bind
// depends on iair_pkg and the top level's ports

module iair_check #(
	parameter int DEPTH = 64
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic [iair_pkg::MODE_W-1:0]        mode,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic signed [iair_pkg::DATA_W-1:0] read_value,
	input logic [iair_pkg::ST_W-1:0]          status,
	input logic [iair_pkg::CNT_W-1:0]         count
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(read_value)
			&& $stable(status) && $stable(count))
		else $error("result changed while stalled");

	// each accepted request gives a result in the next cycle
	a_req_res: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> res_valid)
		else $error("no result after an accepted request");

	// only get returns a non-zero read value
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (mode != iair_pkg::MODE_GET)
			|=> read_value == '0)
		else $error("read value set for a request other than get");

	// full status only with a full array
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == iair_pkg::ST_FULL)
			|-> count == iair_pkg::CNT_W'(DEPTH))
		else $error("full status with a count below depth");

	// count never beyond depth
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (DEPTH > 127) || (int'(count) <= DEPTH))
		else $error("count beyond depth");

endmodule

bind indexed_array_insert_remove iair_check #(.DEPTH(DEPTH)) u_iair_check (.*);

FILE: bench/tb.sv
// testbench for indexed_array_insert_remove: directed table, then random phases
// checks every result against an in-bench prediction of the word array
// depends on iair_pkg and the rtl top level
`timescale 1ns / 100ps

module tb;

	localparam int ARRAY_DEPTH      = 64;
	localparam int RESET_CYCLES     = 2;
	localparam int RANDOM_PER_PHASE = 125;
	localparam int HOLD_CYCLES      = 150;
	localparam int STUCK_LIMIT      = 1000;
	localparam int DRAIN_CYCLES     = 8;

	// mode codes outside the operation set, answered as no-ops
	localparam logic [iair_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [iair_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	// operation mixes for the random phases
	localparam int MIX_GROW   = 0;
	localparam int MIX_SHRINK = 1;
	localparam int MIX_MIXED  = 2;

	typedef struct packed {
		logic [iair_pkg::DATA_W-1:0] rd;
		iair_pkg::status_t           st;
		logic [iair_pkg::CNT_W-1:0]  cnt;
	} array_result_t;

	typedef struct packed {
		logic [iair_pkg::MODE_W-1:0] op;
		logic [iair_pkg::IDX_W-1:0]  idx;
		logic [iair_pkg::DATA_W-1:0] val;
		bit                          typed;
		array_result_t               res;
	} stim_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               req_valid = 1'b0;
	logic                               req_ready;
	logic [iair_pkg::MODE_W-1:0]        mode = '0;
	logic [iair_pkg::IDX_W-1:0]         index = '0;
	logic signed [iair_pkg::DATA_W-1:0] value = '0;
	logic                               res_valid;
	logic                               res_ready = 1'b0;
	logic signed [iair_pkg::DATA_W-1:0] read_value;
	logic [iair_pkg::ST_W-1:0]          status;
	logic [iair_pkg::CNT_W-1:0]         count;

	// predicted contents of the array
	logic [iair_pkg::DATA_W-1:0] array_words [ARRAY_DEPTH];
	int                          array_len = 0;

	array_result_t expected_results [$];
	stim_row_t     stim_rows [$];
	int            failures = 0;
	int            sender_idle_pct = 0;
	int            receiver_stall_pct = 0;
	bit            hold_request = 1'b0;

	indexed_array_insert_remove #(
		.DEPTH(ARRAY_DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.mode      (mode),
		.index     (index),
		.value     (value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.read_value(read_value),
		.status    (status),
		.count     (count)
	);

	always #1 clk = ~clk;

	// apply one request to the predicted array and give its result
	function automatic array_result_t apply_request(
			input logic [iair_pkg::MODE_W-1:0] op,
			input logic [iair_pkg::IDX_W-1:0] idx,
			input logic [iair_pkg::DATA_W-1:0] val);
		array_result_t r;
		int            i;
		r.rd = '0;
		r.st = iair_pkg::ST_OK;
		case (op)
			iair_pkg::MODE_APPEND: begin
				if (array_len >= ARRAY_DEPTH) begin
					r.st = iair_pkg::ST_FULL;
				end else begin
					array_words[array_len] = val;
					array_len++;
				end
			end
			iair_pkg::MODE_INSERT: begin
				// index is checked before fullness
				if (int'(idx) > array_len) begin
					r.st = iair_pkg::ST_BAD_INDEX;
				end else if (array_len >= ARRAY_DEPTH) begin
					r.st = iair_pkg::ST_FULL;
				end else begin
					for (i = array_len; i > int'(idx); i--)
						array_words[i] = array_words[i-1];
					array_words[idx] = val;
					array_len++;
				end
			end
			iair_pkg::MODE_REMOVE: begin
				if (int'(idx) >= array_len) begin
					r.st = iair_pkg::ST_BAD_INDEX;
				end else begin
					for (i = int'(idx); i + 1 < array_len; i++)
						array_words[i] = array_words[i+1];
					array_len--;
				end
			end
			iair_pkg::MODE_GET: begin
				if (int'(idx) >= array_len) begin
					r.st = iair_pkg::ST_BAD_INDEX;
					r.rd = '1;
				end else begin
					r.rd = array_words[idx];
				end
			end
			iair_pkg::MODE_SET: begin
				if (int'(idx) >= array_len)
					r.st = iair_pkg::ST_BAD_INDEX;
				else
					array_words[idx] = val;
			end
			iair_pkg::MODE_CLEAR: begin
				array_len = 0;
			end
			default: begin
			end
		endcase
		r.cnt = array_len[iair_pkg::CNT_W-1:0];
		return r;
	endfunction

	function automatic stim_row_t table_row(input logic [iair_pkg::MODE_W-1:0] op,
			input logic [iair_pkg::IDX_W-1:0] idx, input logic [iair_pkg::DATA_W-1:0] val,
			input bit typed, input logic [iair_pkg::DATA_W-1:0] rd,
			input iair_pkg::status_t st, input logic [iair_pkg::CNT_W-1:0] cnt);
		stim_row_t r;
		r.op = op;
		r.idx = idx;
		r.val = val;
		r.typed = typed;
		r.res.rd = rd;
		r.res.st = st;
		r.res.cnt = cnt;
		return r;
	endfunction

	// offer one request, hold it until taken, then log what should come back
	task automatic send_request(input logic [iair_pkg::MODE_W-1:0] op,
			input logic [iair_pkg::IDX_W-1:0] idx, input logic [iair_pkg::DATA_W-1:0] val,
			input bit typed, input array_result_t typed_res);
		array_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= op;
		index <= idx;
		value <= val;
		do @(posedge clk); while (!req_ready);
		predicted = apply_request(op, idx, val);
		expected_results.push_back(typed ? typed_res : predicted);
	endtask

	// random requests with a given idling pattern and operation mix
	task automatic run_random_phase(input int idle_pct, input int stall_pct, input int mix);
		int                          n;
		int                          pick;
		int                          idx_pick;
		logic [iair_pkg::MODE_W-1:0] op;
		logic [iair_pkg::IDX_W-1:0]  idx;
		logic [iair_pkg::DATA_W-1:0] val;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (n = 0; n < RANDOM_PER_PHASE; n++) begin
			pick = $urandom_range(99);
			if (mix == MIX_GROW) begin
				if (pick < 40) op = iair_pkg::MODE_APPEND;
				else if (pick < 75) op = iair_pkg::MODE_INSERT;
				else if (pick < 80) op = iair_pkg::MODE_REMOVE;
				else if (pick < 90) op = iair_pkg::MODE_GET;
				else if (pick < 97) op = iair_pkg::MODE_SET;
				else if (pick < 99) op = MODE_SPARE_LO;
				else op = iair_pkg::MODE_CLEAR;
			end else if (mix == MIX_SHRINK) begin
				if (pick < 10) op = iair_pkg::MODE_APPEND;
				else if (pick < 20) op = iair_pkg::MODE_INSERT;
				else if (pick < 60) op = iair_pkg::MODE_REMOVE;
				else if (pick < 80) op = iair_pkg::MODE_GET;
				else if (pick < 94) op = iair_pkg::MODE_SET;
				else if (pick < 97) op = MODE_SPARE_HI;
				else op = iair_pkg::MODE_CLEAR;
			end else begin
				if (pick < 25) op = iair_pkg::MODE_APPEND;
				else if (pick < 45) op = iair_pkg::MODE_INSERT;
				else if (pick < 65) op = iair_pkg::MODE_REMOVE;
				else if (pick < 82) op = iair_pkg::MODE_GET;
				else if (pick < 93) op = iair_pkg::MODE_SET;
				else if (pick < 96) op = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
				else op = iair_pkg::MODE_CLEAR;
			end
			// mostly in-range indexes, some anywhere in the field
			if ($urandom_range(99) < 15)
				idx_pick = $urandom_range(127);
			else if (op == iair_pkg::MODE_INSERT)
				idx_pick = $urandom_range(array_len);
			else if (array_len == 0)
				idx_pick = 0;
			else
				idx_pick = $urandom_range(array_len - 1);
			idx = idx_pick[iair_pkg::IDX_W-1:0];
			case ($urandom_range(19))
				0: val = 32'h8000_0000;
				1: val = 32'h7FFF_FFFF;
				2: val = 32'hFFFF_FFFF;
				3: val = 32'h0000_0000;
				default: val = $urandom;
			endcase
			send_request(op, idx, val, 1'b0, '0);
		end
	endtask

	// result side: check each taken result, then choose ready for the next edge
	initial begin : result_side
		array_result_t exp_res;
		int            hold_left;
		bit            hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result read_value %h status %0d count %0d",
						$time, read_value, status, count);
					failures++;
				end else begin
					exp_res = expected_results.pop_front();
					if (read_value !== exp_res.rd) begin
						$display("%0t: read_value expected %h actual %h",
							$time, exp_res.rd, read_value);
						failures++;
					end
					if (status !== exp_res.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_res.st, status);
						failures++;
					end
					if (count !== exp_res.cnt) begin
						$display("%0t: count expected %0d actual %0d",
							$time, exp_res.cnt, count);
						failures++;
					end
				end
			end
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// watchdog on cycles with no request or result taken
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (res_valid && res_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("indexed_array_insert_remove: mismatch");
		$finish;
	end

	initial begin : stimulus
		int r;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty array: get, remove and set at index 0 and insert at 1 are out of range
		stim_rows.push_back(table_row(iair_pkg::MODE_GET, 0, 32'h0, 1,
			32'hFFFF_FFFF, iair_pkg::ST_BAD_INDEX, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_REMOVE, 0, 32'h0, 1,
			32'h0, iair_pkg::ST_BAD_INDEX, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_SET, 0, 32'h1234_5678, 1,
			32'h0, iair_pkg::ST_BAD_INDEX, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_INSERT, 1, 32'h5, 1,
			32'h0, iair_pkg::ST_BAD_INDEX, 0));
		// insert at the head, append ignores its index, value extremes
		stim_rows.push_back(table_row(iair_pkg::MODE_INSERT, 0, 32'h7FFF_FFFF, 1,
			32'h0, iair_pkg::ST_OK, 1));
		stim_rows.push_back(table_row(iair_pkg::MODE_APPEND, 127, 32'h8000_0000, 1,
			32'h0, iair_pkg::ST_OK, 2));
		stim_rows.push_back(table_row(iair_pkg::MODE_INSERT, 1, 32'h0, 0,
			32'h0, iair_pkg::ST_OK, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_GET, 0, 32'h0, 1,
			32'h7FFF_FFFF, iair_pkg::ST_OK, 3));
		stim_rows.push_back(table_row(iair_pkg::MODE_GET, 2, 32'h0, 1,
			32'h8000_0000, iair_pkg::ST_OK, 3));
		stim_rows.push_back(table_row(iair_pkg::MODE_GET, 1, 32'h0, 0,
			32'h0, iair_pkg::ST_OK, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_SET, 1, 32'hFFFF_FFFF, 0,
			32'h0, iair_pkg::ST_OK, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_GET, 1, 32'h0, 0,
			32'h0, iair_pkg::ST_OK, 0));
		// insert at index equal to the count is allowed, one beyond is not
		stim_rows.push_back(table_row(iair_pkg::MODE_INSERT, 3, 32'h5555_5555, 0,
			32'h0, iair_pkg::ST_OK, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_INSERT, 5, 32'h1, 1,
			32'h0, iair_pkg::ST_BAD_INDEX, 4));
		stim_rows.push_back(table_row(iair_pkg::MODE_REMOVE, 0, 32'h0, 0,
			32'h0, iair_pkg::ST_OK, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_GET, 0, 32'h0, 0,
			32'h0, iair_pkg::ST_OK, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_REMOVE, 3, 32'h0, 1,
			32'h0, iair_pkg::ST_BAD_INDEX, 3));
		stim_rows.push_back(table_row(iair_pkg::MODE_GET, 127, 32'h0, 1,
			32'hFFFF_FFFF, iair_pkg::ST_BAD_INDEX, 3));
		stim_rows.push_back(table_row(iair_pkg::MODE_SET, 64, 32'hAAAA_AAAA, 1,
			32'h0, iair_pkg::ST_BAD_INDEX, 3));
		// unused mode codes change nothing
		stim_rows.push_back(table_row(MODE_SPARE_LO, 5, 32'hFFFF_FFFF, 1,
			32'h0, iair_pkg::ST_OK, 3));
		stim_rows.push_back(table_row(MODE_SPARE_HI, 127, 32'hFFFF_FFFF, 1,
			32'h0, iair_pkg::ST_OK, 3));
		stim_rows.push_back(table_row(iair_pkg::MODE_CLEAR, 127, 32'hFFFF_FFFF, 1,
			32'h0, iair_pkg::ST_OK, 0));
		stim_rows.push_back(table_row(iair_pkg::MODE_GET, 0, 32'h0, 1,
			32'hFFFF_FFFF, iair_pkg::ST_BAD_INDEX, 0));

		for (r = 0; r < stim_rows.size(); r++)
			send_request(stim_rows[r].op, stim_rows[r].idx, stim_rows[r].val,
				stim_rows[r].typed, stim_rows[r].res);

		// long receiver hold so the result register backs up the input
		hold_request = 1'b1;
		run_random_phase(0, 0, MIX_GROW);
		run_random_phase(48, 0, MIX_SHRINK);
		run_random_phase(0, 48, MIX_GROW);
		run_random_phase(17, 17, MIX_MIXED);

		req_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("indexed_array_insert_remove: match");
		else
			$display("indexed_array_insert_remove: mismatch");
		$finish;
	end

endmodule
